>>> rtl/core/cdfb_pkg.sv
// Package for the calibrated DAC frame builder: field widths, control bytes,
// register indexes, reset values and the item structs passed between stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdfb_pkg;

   localparam int VoltsWidth = 32;
   localparam int CodeWidth  = 16;
   localparam int FrameWidth = 24;
   localparam int SlopeWidth = 32;
   localparam int CsrIdxWidth = 4;
   localparam int CsrDataWidth = 32;

   // Divider widths: numerator is |diff| * 512 + slope, divisor 2 * slope.
   localparam int DiffWidth = VoltsWidth + 1;
   localparam int NumWidth  = DiffWidth + 9;
   localparam int DenWidth  = SlopeWidth + 1;
   localparam int RemWidth  = DenWidth;
   localparam int DivSteps  = CodeWidth;

   localparam logic [7:0] CTRL_OUT_A = 8'h24;
   localparam logic [7:0] CTRL_OUT_B = 8'h10;
   localparam logic [CodeWidth-1:0] CODE_MAX = 16'hFFFF;

   localparam logic [CsrIdxWidth-1:0] REG_SLOPE_A  = 4'd0;
   localparam logic [CsrIdxWidth-1:0] REG_OFFSET_A = 4'd1;
   localparam logic [CsrIdxWidth-1:0] REG_SLOPE_B  = 4'd2;
   localparam logic [CsrIdxWidth-1:0] REG_OFFSET_B = 4'd3;

   localparam logic [SlopeWidth-1:0] SLOPE_RESET  = 32'd655370;
   localparam logic [VoltsWidth-1:0] OFFSET_RESET = 32'd0;

   localparam logic CMD_VOLTS = 1'b0;
   localparam logic CMD_RAW   = 1'b1;

   typedef struct packed {
      logic [SlopeWidth-1:0] slope_a;
      logic [VoltsWidth-1:0] offset_a;
      logic [SlopeWidth-1:0] slope_b;
      logic [VoltsWidth-1:0] offset_b;
   } cal_type;

   typedef struct packed {
      logic                  cmd;
      logic                  jack;
      logic [VoltsWidth-1:0] target_volts;
      logic [CodeWidth-1:0]  raw_code;
   } req_item_type;

   typedef struct packed {
      logic                 cmd;
      logic                 jack;
      logic                 neg;
      logic                 ovf;
      logic [CodeWidth-1:0] raw_code;
      logic [DenWidth-1:0]  den;
      logic [RemWidth-1:0]  rem;
      logic [CodeWidth-1:0] num_low;
      logic [CodeWidth-1:0] quo;
   } div_item_type;

endpackage

`default_nettype wire

>>> rtl/core/cdfb_ifs.sv
// Handshake interfaces of the DAC frame builder: request, response and
// register write channels. Depends on cdfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cdfb_req_if;
   import cdfb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic                  jack;
   logic [VoltsWidth-1:0] target_volts;
   logic [CodeWidth-1:0]  raw_code;
   modport source (output valid, cmd, jack, target_volts, raw_code, input ready);
   modport sink (input valid, cmd, jack, target_volts, raw_code, output ready);
endinterface

interface cdfb_rsp_if;
   import cdfb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [FrameWidth-1:0] frame;
   logic [CodeWidth-1:0]  dac_code;
   logic                  saturated;
   modport source (output valid, frame, dac_code, saturated, input ready);
   modport sink (input valid, frame, dac_code, saturated, output ready);
endinterface

interface cdfb_csr_if;
   import cdfb_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CsrIdxWidth-1:0]  index;
   logic [CsrDataWidth-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cdfb_cal_regs.sv
// Calibration register file: slope and offset for outputs A and B.
// Depends on cdfb_pkg and cdfb_csr_if.
`timescale 1ns / 1ps
`default_nettype none

module cdfb_cal_regs (
   input  wire              clock,
   input  wire              reset,
   cdfb_csr_if.sink         csr_bus,
   output cdfb_pkg::cal_type cal
);
   import cdfb_pkg::*;

   cal_type cal_ff;
   cal_type cal_in;

   assign csr_bus.ready = 1'b1;
   assign cal = cal_ff;

   always_comb begin
      cal_in = cal_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_SLOPE_A:  cal_in.slope_a  = csr_bus.data;
            REG_OFFSET_A: cal_in.offset_a = csr_bus.data;
            REG_SLOPE_B:  cal_in.slope_b  = csr_bus.data;
            REG_OFFSET_B: cal_in.offset_b = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.slope_a  <= SLOPE_RESET;
         cal_ff.offset_a <= OFFSET_RESET;
         cal_ff.slope_b  <= SLOPE_RESET;
         cal_ff.offset_b <= OFFSET_RESET;
      end else begin
         cal_ff <= cal_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/cdfb_front.sv
// Front end of the conversion pipeline: offset subtraction, magnitude,
// rounding numerator and overflow test, one register stage each.
// Depends on cdfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdfb_front (
   input  wire                    clock,
   input  wire                    reset,
   input  cdfb_pkg::cal_type      cal,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  cdfb_pkg::req_item_type in_item,
   output logic                   out_valid,
   input  wire                    out_ready,
   output cdfb_pkg::div_item_type out_item
);
   import cdfb_pkg::*;

   // Stage 1: signed difference against the selected offset.
   logic                  s1_valid_ff;
   logic                  s1_cmd_ff, s1_jack_ff;
   logic [CodeWidth-1:0]  s1_raw_ff;
   logic [DiffWidth-1:0]  s1_diff_ff, s1_diff_in;
   logic [SlopeWidth-1:0] s1_slope_ff, s1_slope_in;
   logic                  s1_ready;
   logic [VoltsWidth-1:0] off_sel;

   // Stage 2: sign and magnitude.
   logic                  s2_valid_ff;
   logic                  s2_cmd_ff, s2_jack_ff, s2_neg_ff;
   logic [CodeWidth-1:0]  s2_raw_ff;
   logic [DiffWidth-1:0]  s2_mag_ff, s2_mag_in;
   logic [SlopeWidth-1:0] s2_slope_ff;
   logic                  s2_ready;

   // Stage 3: numerator and divisor for the rounded quotient.
   logic                  s3_valid_ff;
   logic                  s3_cmd_ff, s3_jack_ff, s3_neg_ff;
   logic [CodeWidth-1:0]  s3_raw_ff;
   logic [NumWidth-1:0]   s3_num_ff, s3_num_in;
   logic [DenWidth-1:0]   s3_den_ff;
   logic                  s3_ready;

   // Stage 4: overflow test and divider seed.
   logic                  s4_valid_ff;
   div_item_type          s4_item_ff, s4_item_in;
   logic                  s4_ready;

   assign off_sel     = in_item.jack ? cal.offset_b : cal.offset_a;
   assign s1_diff_in  = {in_item.target_volts[VoltsWidth-1], in_item.target_volts}
                        - {off_sel[VoltsWidth-1], off_sel};
   always_comb begin
      s1_slope_in = in_item.jack ? cal.slope_b : cal.slope_a;
      // A zero slope is treated as the smallest slope.
      if (s1_slope_in == '0) begin
         s1_slope_in = SlopeWidth'(1);
      end
   end

   assign s2_mag_in = s1_diff_ff[DiffWidth-1] ? (~s1_diff_ff + DiffWidth'(1)) : s1_diff_ff;
   assign s3_num_in = {s2_mag_ff, 9'd0} + NumWidth'(s2_slope_ff);

   always_comb begin
      s4_item_in          = '0;
      s4_item_in.cmd      = s3_cmd_ff;
      s4_item_in.jack     = s3_jack_ff;
      s4_item_in.neg      = s3_neg_ff;
      s4_item_in.raw_code = s3_raw_ff;
      s4_item_in.den      = s3_den_ff;
      s4_item_in.ovf      = ((NumWidth + 7)'(s3_num_ff) >= (NumWidth + 7)'({s3_den_ff, 16'd0}));
      s4_item_in.rem      = RemWidth'(s3_num_ff[NumWidth-1:CodeWidth]);
      s4_item_in.num_low  = s3_num_ff[CodeWidth-1:0];
   end

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign out_valid = s4_valid_ff;
   assign out_item  = s4_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_cmd_ff   <= in_item.cmd;
         s1_jack_ff  <= in_item.jack;
         s1_raw_ff   <= in_item.raw_code;
         s1_diff_ff  <= s1_diff_in;
         s1_slope_ff <= s1_slope_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_cmd_ff   <= s1_cmd_ff;
         s2_jack_ff  <= s1_jack_ff;
         s2_raw_ff   <= s1_raw_ff;
         s2_neg_ff   <= s1_diff_ff[DiffWidth-1];
         s2_mag_ff   <= s2_mag_in;
         s2_slope_ff <= s1_slope_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_cmd_ff  <= s2_cmd_ff;
         s3_jack_ff <= s2_jack_ff;
         s3_raw_ff  <= s2_raw_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_num_ff  <= s3_num_in;
         s3_den_ff  <= {s2_slope_ff, 1'b0};
      end
      if (s4_ready && s3_valid_ff) begin
         s4_item_ff <= s4_item_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/cdfb_div_stage.sv
// One restoring-division step with its pipeline register: brings down one
// numerator bit and produces one quotient bit. Depends on cdfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdfb_div_stage (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  cdfb_pkg::div_item_type in_item,
   output logic                   out_valid,
   input  wire                    out_ready,
   output cdfb_pkg::div_item_type out_item
);
   import cdfb_pkg::*;

   logic                valid_ff;
   div_item_type        item_ff, item_in;
   logic [RemWidth:0]   trial;
   logic [RemWidth:0]   diff;
   logic                qbit;

   assign trial = {in_item.rem, in_item.num_low[CodeWidth-1]};
   assign diff  = trial - {1'b0, in_item.den};
   assign qbit  = (trial >= {1'b0, in_item.den});

   always_comb begin
      item_in         = in_item;
      item_in.rem     = qbit ? diff[RemWidth-1:0] : trial[RemWidth-1:0];
      item_in.num_low = {in_item.num_low[CodeWidth-2:0], 1'b0};
      item_in.quo     = {in_item.quo[CodeWidth-2:0], qbit};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/calibrated_dac_frame_builder.sv
// Top level of the calibrated DAC frame builder: register file, pipeline
// front end, sixteen division steps and the frame output register.
// Depends on cdfb_pkg, cdfb_ifs, cdfb_cal_regs, cdfb_front, cdfb_div_stage.
//
// Usage: each item on req_bus either converts target_volts (cmd 0) or passes
// raw_code (cmd 1) for output A (jack 0) or output B (jack 1). A voltage has
// the selected offset removed, is divided by the selected slope, rounded
// half away from zero and clamped to 0..65535, with saturated set when the
// code had to be clamped. Exactly one item leaves on rsp_bus per input item,
// carrying the 24-bit frame (control byte 0x24 for A, 0x10 for B, then the
// code) and the code itself.
// Calibration is written on csr_bus (index 0 slope_a, 1 offset_a, 2 slope_b,
// 3 offset_b), which is always ready; write it only while the pipeline is
// empty. An item passes 21 registers: four front-end stages, one stage per
// quotient bit of the sixteen-step restoring divider, and the output
// register; the first is loaded at the accepting edge. Throughput is one
// item per cycle while rsp_bus takes items. When rsp_bus stalls, items
// close up behind the output register into empty stages, and req_bus.ready
// falls only once the pipeline is full.
// Reset empties the pipeline and loads the calibration reset values.
`timescale 1ns / 1ps
`default_nettype none

module calibrated_dac_frame_builder (
   input  wire         clock,
   input  wire         reset,
   cdfb_csr_if.sink    csr_bus,
   cdfb_req_if.sink    req_bus,
   cdfb_rsp_if.source  rsp_bus
);
   import cdfb_pkg::*;

   cal_type       cal;
   req_item_type  req_item;

   // Stage handshakes: index 0 is the front end output, index k the output
   // of division step k.
   logic          stg_valid [DivSteps+1];
   logic          stg_ready [DivSteps+1];
   div_item_type  stg_item  [DivSteps+1];

   // Output register.
   logic                  out_valid_ff;
   logic [FrameWidth-1:0] frame_ff, frame_in;
   logic [CodeWidth-1:0]  code_ff, code_in;
   logic                  sat_ff, sat_in;
   logic                  out_ready;
   div_item_type          last;

   cdfb_cal_regs u_cal_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cal     (cal)
   );

   assign req_item.cmd          = req_bus.cmd;
   assign req_item.jack         = req_bus.jack;
   assign req_item.target_volts = req_bus.target_volts;
   assign req_item.raw_code     = req_bus.raw_code;

   cdfb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_item   (req_item),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_item  (stg_item[0])
   );

   // One quotient bit per stage, most significant first.
   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      cdfb_div_stage u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_item   (stg_item[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_item  (stg_item[k+1])
      );
   end

   assign last = stg_item[DivSteps];

   // Code selection. A negative quotient gives code zero and is flagged
   // only when it did not round to zero; the overflow test covers any
   // quotient above the code range, whose divider bits are then unused.
   always_comb begin
      sat_in  = 1'b0;
      code_in = last.quo;
      if (last.cmd == CMD_RAW) begin
         code_in = last.raw_code;
      end else if (last.neg) begin
         code_in = '0;
         sat_in  = last.ovf || (last.quo != '0);
      end else if (last.ovf) begin
         code_in = CODE_MAX;
         sat_in  = 1'b1;
      end
      frame_in = {(last.jack ? CTRL_OUT_B : CTRL_OUT_A), code_in};
   end

   assign out_ready            = !out_valid_ff || rsp_bus.ready;
   assign stg_ready[DivSteps]  = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= stg_valid[DivSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && stg_valid[DivSteps]) begin
         frame_ff <= frame_in;
         code_ff  <= code_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.frame     = frame_ff;
   assign rsp_bus.dac_code  = code_ff;
   assign rsp_bus.saturated = sat_ff;

`ifndef NO_ASSERTIONS
   // A clamped code sits at one of the two range limits.
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.saturated |->
         (rsp_bus.dac_code == '0) || (rsp_bus.dac_code == CODE_MAX))
      else $error("saturated result with a code inside the range");

   // The frame's low bytes carry the reported code.
   a_frame_code: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.frame[CodeWidth-1:0] == rsp_bus.dac_code)
      else $error("frame code bytes differ from dac_code");

   // The control byte is one of the two output selections.
   a_ctrl_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.frame[FrameWidth-1:CodeWidth] == CTRL_OUT_A) ||
                        (rsp_bus.frame[FrameWidth-1:CodeWidth] == CTRL_OUT_B))
      else $error("unknown control byte in frame");

   // A free-flowing output never holds back the input.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.ready |-> req_bus.ready)
      else $error("input stalled while the output is taking items");
`endif

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking bench for calibrated_dac_frame_builder: drives voltage and raw-code
// items under random back-pressure and checks every frame against an in-bench model.
// Depends on cdfb_pkg, the cdfb_ifs interfaces and the RTL of the block.
`timescale 1ns / 1ps

module tb;
   import cdfb_pkg::*;

   localparam int ClockPeriod = 10;
   localparam int ResetCycles = 11;
   // Wait after the last expected frame before the next check starts.
   localparam int SettleCycles = 30;
   localparam int CycleLimit = 200000;
   localparam int ItemsPerPhase = 200;
   localparam int RandomPhases = 8;
   localparam int ReportedMismatches = 10;

   localparam logic JACK_A = 1'b0;
   localparam logic JACK_B = 1'b1;

   // One frame as it should leave the block.
   typedef struct packed {
      logic [FrameWidth-1:0] frame;
      logic [CodeWidth-1:0]  dac_code;
      logic                  saturated;
   } dac_frame_type;

   logic clock;
   logic reset;

   cdfb_csr_if csr_bus ();
   cdfb_req_if req_bus ();
   cdfb_rsp_if rsp_bus ();

   calibrated_dac_frame_builder dut (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Bench copy of the calibration registers; it is updated at the edge where
   // the register write is accepted, so it always matches the block's view.
   cal_type cal_shadow;

   // Frames predicted for accepted items, oldest first.
   dac_frame_type pending_frames[$];

   int  mismatch_count;
   int  cycle_count;
   // When cleared, neither side of the data path inserts gaps or stalls.
   bit  traffic_gaps;

   dac_frame_type observed_frame;
   dac_frame_type wanted_frame;

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // Converts one item into the frame that the block must produce, using the
   // calibration of the selected output. The quotient is formed exactly in 64
   // bits: |volts - offset| * 256 / slope, rounded half away from zero by
   // adding half the divisor before the division.
   function automatic dac_frame_type build_frame(input cal_type cal, input logic cmd,
                                                 input logic jack,
                                                 input logic [VoltsWidth-1:0] volts,
                                                 input logic [CodeWidth-1:0] raw);
      logic [VoltsWidth-1:0] offset;
      logic [SlopeWidth-1:0] slope;
      logic signed [33:0]    diff;
      logic [63:0]           magnitude;
      logic [63:0]           divisor;
      logic [63:0]           quotient;
      logic [7:0]            control;
      dac_frame_type         result;
      offset = (jack == JACK_B) ? cal.offset_b : cal.offset_a;
      slope = (jack == JACK_B) ? cal.slope_b : cal.slope_a;
      result.saturated = 1'b0;
      if (cmd == CMD_RAW) begin
         // Raw codes bypass calibration entirely and are never flagged.
         result.dac_code = raw;
      end else begin
         diff = $signed({{2{volts[31]}}, volts}) - $signed({{2{offset[31]}}, offset});
         magnitude = diff[33] ? 64'(-diff) : 64'(diff);
         magnitude = magnitude << 8;
         // A slope register holding zero acts as a slope of one.
         divisor = (slope == '0) ? 64'd1 : 64'(slope);
         quotient = (2 * magnitude + divisor) / (2 * divisor);
         if (diff[33]) begin
            // Negative quotients clamp to zero; only those that round to a
            // nonzero magnitude count as saturated.
            result.dac_code = '0;
            result.saturated = (quotient != 0);
         end else if (quotient > 64'(CODE_MAX)) begin
            result.dac_code = CODE_MAX;
            result.saturated = 1'b1;
         end else begin
            result.dac_code = quotient[CodeWidth-1:0];
         end
      end
      // The outputs are cross-wired: output A goes out with the 0x24 control
      // byte and output B with 0x10.
      control = (jack == JACK_B) ? CTRL_OUT_B : CTRL_OUT_A;
      result.frame = {control, result.dac_code};
      return result;
   endfunction

   // Picks a target voltage for the selected output. Most values are aimed at
   // the useful code range or straddle a rounding point at the ends of it, so
   // that rounding and clamping get exercised under any calibration; the rest
   // are uniform over the whole 32-bit range.
   function automatic logic [VoltsWidth-1:0] pick_volts(input logic jack);
      longint offset_l;
      longint slope_l;
      longint code_l;
      longint volts_l;
      int     jitter;
      int     mode;
      offset_l = longint'($signed((jack == JACK_B) ? cal_shadow.offset_b
                                                   : cal_shadow.offset_a));
      slope_l = longint'((jack == JACK_B) ? cal_shadow.slope_b : cal_shadow.slope_a);
      mode = $urandom_range(99);
      jitter = int'($urandom_range(8)) - 4;
      if (mode < 45) begin
         code_l = longint'($urandom_range(65535));
         volts_l = offset_l + ((code_l * slope_l) >>> 8) + jitter;
      end else if (mode < 70) begin
         // Land on or next to a half-code point near zero or full scale.
         case ($urandom_range(3))
            0: code_l = 0;
            1: code_l = 1;
            2: code_l = 65535;
            default: code_l = 65536;
         endcase
         code_l = 2 * code_l + longint'($urandom_range(2)) - 1;
         if ($urandom_range(1) == 1) code_l = -code_l;
         volts_l = offset_l + (code_l * slope_l) / 512 + (jitter / 2);
      end else begin
         volts_l = longint'($urandom);
      end
      return 32'(volts_l);
   endfunction

   function automatic logic [SlopeWidth-1:0] pick_slope();
      case ($urandom_range(9))
         0: return 32'($urandom_range(1, 255));
         1: return $urandom;
         2: return 32'hFFFF_FFFF;
         3: return 32'd0;
         default: return 32'($urandom_range(1 << 14, 1 << 22));
      endcase
   endfunction

   function automatic logic [VoltsWidth-1:0] pick_offset();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         default: return 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
      endcase
   endfunction

   // Writes one calibration register and mirrors it into the shadow copy.
   task automatic write_reg(input logic [CsrIdxWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (index)
         REG_SLOPE_A:  cal_shadow.slope_a = value;
         REG_OFFSET_A: cal_shadow.offset_a = value;
         REG_SLOPE_B:  cal_shadow.slope_b = value;
         REG_OFFSET_B: cal_shadow.offset_b = value;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Offers one item and returns at the edge where it is accepted. Valid stays
   // high afterwards so that the next item can follow without a gap; a random
   // gap lowers it for whole cycles before the next item is shown.
   task automatic send_request(input logic cmd, input logic jack,
                               input logic [VoltsWidth-1:0] volts,
                               input logic [CodeWidth-1:0] raw);
      @(negedge clock);
      while (traffic_gaps && $urandom_range(99) < 13) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.jack <= jack;
      req_bus.target_volts <= volts;
      req_bus.raw_code <= raw;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Stops offering items and waits until every predicted frame has arrived,
   // then for SettleCycles more, so that the block is idle afterwards.
   task automatic wait_for_frames();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Reset calibration: about 10 V full scale with no offset on both outputs.
   task automatic check_reset_calibration();
      send_request(CMD_VOLTS, JACK_A, 32'd0, 16'hFFFF);
      send_request(CMD_VOLTS, JACK_B, 32'd16777216, 16'h0000);
      send_request(CMD_VOLTS, JACK_A, 32'd167772160, 16'h1234);
      send_request(CMD_VOLTS, JACK_B, 32'h7FFF_FFFF, 16'h0000);
      send_request(CMD_VOLTS, JACK_A, 32'h8000_0000, 16'hFFFF);
      wait_for_frames();
   endtask

   // Raw codes ignore the voltage field and the calibration.
   task automatic check_raw_codes();
      send_request(CMD_RAW, JACK_A, 32'h7FFF_FFFF, 16'h0000);
      send_request(CMD_RAW, JACK_B, 32'h8000_0000, 16'hFFFF);
      send_request(CMD_RAW, JACK_A, 32'hFFFF_FFFF, 16'hA5A5);
      wait_for_frames();
   endtask

   // With a slope of 512 one volt unit is half a code, and with 1024 a
   // quarter, which puts items exactly on the rounding and clamping points.
   task automatic check_rounding_edges();
      write_reg(REG_SLOPE_A, 32'd512);
      write_reg(REG_OFFSET_A, 32'd0);
      write_reg(REG_SLOPE_B, 32'd1024);
      write_reg(REG_OFFSET_B, 32'd0);
      send_request(CMD_VOLTS, JACK_A, 32'd1, 16'h0000);
      send_request(CMD_VOLTS, JACK_A, 32'hFFFF_FFFF, 16'h0000);
      send_request(CMD_VOLTS, JACK_A, 32'd131070, 16'h0000);
      send_request(CMD_VOLTS, JACK_A, 32'd131071, 16'h0000);
      send_request(CMD_VOLTS, JACK_B, 32'hFFFF_FFFF, 16'h0000);
      send_request(CMD_VOLTS, JACK_B, 32'hFFFF_FFFE, 16'h0000);
      send_request(CMD_VOLTS, JACK_B, 32'd2, 16'h0000);
      wait_for_frames();
   endtask

   // Largest positive and negative differences, and extreme slopes.
   task automatic check_offset_extremes();
      write_reg(REG_SLOPE_A, 32'hFFFF_FFFF);
      write_reg(REG_OFFSET_A, 32'h8000_0000);
      write_reg(REG_SLOPE_B, 32'd1);
      write_reg(REG_OFFSET_B, 32'h7FFF_FFFF);
      send_request(CMD_VOLTS, JACK_A, 32'h7FFF_FFFF, 16'h0000);
      send_request(CMD_VOLTS, JACK_B, 32'h8000_0000, 16'h0000);
      send_request(CMD_VOLTS, JACK_B, 32'h7FFF_FFFF, 16'h0000);
      wait_for_frames();
   endtask

   // A zero slope behaves as a slope of one.
   task automatic check_zero_slope();
      write_reg(REG_SLOPE_A, 32'd0);
      write_reg(REG_OFFSET_A, 32'd0);
      write_reg(REG_SLOPE_B, 32'd0);
      write_reg(REG_OFFSET_B, 32'hFFFF_FFFB);
      send_request(CMD_VOLTS, JACK_A, 32'd255, 16'h0000);
      send_request(CMD_VOLTS, JACK_A, 32'd256, 16'h0000);
      send_request(CMD_VOLTS, JACK_B, 32'hFFFF_FFFB, 16'h0000);
      wait_for_frames();
   endtask

   // Random items over several calibrations. Phase one and phase five use
   // extreme register values; phase two runs with no gaps and no stalls.
   task automatic check_random_traffic();
      logic                  cmd;
      logic                  jack;
      logic [VoltsWidth-1:0] volts;
      for (int phase = 0; phase < RandomPhases; phase++) begin
         if (phase == 1) begin
            write_reg(REG_SLOPE_A, 32'd1);
            write_reg(REG_OFFSET_A, 32'h8000_0000);
            write_reg(REG_SLOPE_B, 32'hFFFF_FFFF);
            write_reg(REG_OFFSET_B, 32'h7FFF_FFFF);
         end else if (phase == 5) begin
            write_reg(REG_SLOPE_A, 32'hFFFF_FFFF);
            write_reg(REG_OFFSET_A, 32'h7FFF_FFFF);
            write_reg(REG_SLOPE_B, 32'd1);
            write_reg(REG_OFFSET_B, 32'h8000_0000);
         end else begin
            write_reg(REG_SLOPE_A, pick_slope());
            write_reg(REG_OFFSET_A, pick_offset());
            write_reg(REG_SLOPE_B, pick_slope());
            write_reg(REG_OFFSET_B, pick_offset());
         end
         traffic_gaps = (phase != 2);
         for (int n = 0; n < ItemsPerPhase; n++) begin
            cmd = ($urandom_range(99) < 15) ? CMD_RAW : CMD_VOLTS;
            jack = 1'($urandom_range(1));
            volts = (cmd == CMD_VOLTS) ? pick_volts(jack) : $urandom;
            send_request(cmd, jack, volts, 16'($urandom));
         end
         wait_for_frames();
      end
      traffic_gaps = 1'b1;
   endtask

   // Result side back-pressure: mostly single-cycle stalls, with an
   // occasional long one that lets the pipeline fill and push back on the
   // request side.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!traffic_gaps || reset) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(999) < 8) begin
            stall_left = $urandom_range(20, 40);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 12);
         end
      end
   end

   // Scoreboard. Results are compared before the prediction for this edge
   // is queued, so the outcome never depends on process order; a frame can
   // only belong to an item accepted on an earlier edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            observed_frame.frame = rsp_bus.frame;
            observed_frame.dac_code = rsp_bus.dac_code;
            observed_frame.saturated = rsp_bus.saturated;
            if (pending_frames.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= ReportedMismatches)
                  $display("%0t: unexpected frame %h code %h sat %b", $realtime,
                           observed_frame.frame, observed_frame.dac_code,
                           observed_frame.saturated);
            end else begin
               wanted_frame = pending_frames.pop_front();
               if (observed_frame.frame !== wanted_frame.frame ||
                   observed_frame.dac_code !== wanted_frame.dac_code ||
                   observed_frame.saturated !== wanted_frame.saturated) begin
                  mismatch_count++;
                  if (mismatch_count <= ReportedMismatches)
                     $display({"%0t: frame mismatch, expected frame %h code %h sat %b,",
                               " got frame %h code %h sat %b"}, $realtime,
                              wanted_frame.frame, wanted_frame.dac_code,
                              wanted_frame.saturated, observed_frame.frame,
                              observed_frame.dac_code, observed_frame.saturated);
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            pending_frames.push_back(build_frame(cal_shadow, req_bus.cmd, req_bus.jack,
                                                 req_bus.target_volts,
                                                 req_bus.raw_code));
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL calibrated_dac_frame_builder");
      $finish;
   end

   initial begin
      mismatch_count = 0;
      traffic_gaps = 1'b1;
      reset = 1'b1;
      cal_shadow.slope_a = SLOPE_RESET;
      cal_shadow.offset_a = OFFSET_RESET;
      cal_shadow.slope_b = SLOPE_RESET;
      cal_shadow.offset_b = OFFSET_RESET;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_VOLTS;
      req_bus.jack = JACK_A;
      req_bus.target_volts = '0;
      req_bus.raw_code = '0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_reset_calibration();
      check_raw_codes();
      check_rounding_edges();
      check_offset_extremes();
      check_zero_slope();
      check_random_traffic();

      if (mismatch_count == 0)
         $display("PASS calibrated_dac_frame_builder");
      else
         $display("FAIL calibrated_dac_frame_builder");
      $finish;
   end

endmodule
